@@ rtl/muqs_pkg.sv @@
// Package for the muon identification quality selector.
// Holds candidate, configuration and result types, register indexes,
// reset values and the small shift-add helpers used by the cut evaluation.
package muqs_pkg;

    // Field widths of one candidate.
    localparam int FLAGS_W = 10;
    localparam int HITS_W  = 24;
    localparam int CHI2_W  = 16;
    localparam int PT_W    = 22;
    localparam int HIT8_W  = 8;
    localparam int NMU_W   = 10;

    // Stream widths: tdata carries every field but the flags, padded to bytes.
    localparam int IN_DATA_BITS = HITS_W + 2 * CHI2_W + 7 * PT_W;
    localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int RES_W        = 7;
    localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIT_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SA_CHI2_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLB_CHI2_MAX_LOOSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLB_CHI2_RESCUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRK_PT_MAX_LOOSE  = 3'd4;

    // Fixed hit thresholds of the global-tight branch.
    localparam logic [HIT8_W-1:0] DT_HITS_MIN  = 8'd22;
    localparam logic [HIT8_W-1:0] CSC_HITS_MIN = 8'd15;

    // Type flag bit positions.
    localparam int FL_PRESENT  = 0;
    localparam int FL_GLOBAL   = 1;
    localparam int FL_TRACKER  = 2;
    localparam int FL_STANDALN = 3;
    localparam int FL_ISO_VAL  = 4;
    localparam int FL_PROMPT   = 5;
    localparam int FL_COMPAT2D = 6;
    localparam int FL_ARBITR   = 7;
    localparam int FL_ONE_ST   = 8;
    localparam int FL_LAST_ANG = 9;

    // One candidate; the lowest fields sit in the lowest bits.
    typedef struct packed {
        logic [FLAGS_W-1:0] type_flags;
        logic [PT_W-1:0]    isolation_sum;
        logic [PT_W-1:0]    tracker_pt_error;
        logic [PT_W-1:0]    tracker_pt;
        logic [PT_W-1:0]    global_pt_error;
        logic [PT_W-1:0]    global_pt;
        logic [PT_W-1:0]    standalone_pt_error;
        logic [PT_W-1:0]    standalone_pt;
        logic [CHI2_W-1:0]  global_chi2;
        logic [CHI2_W-1:0]  standalone_chi2;
        logic [HITS_W-1:0]  hit_counts;
    } t_cand;

    // Configuration register set.
    typedef struct packed {
        logic [HIT8_W-1:0] min_hit_count;
        logic [CHI2_W-1:0] standalone_chi2_max;
        logic [CHI2_W-1:0] global_chi2_max_loose;
        logic [CHI2_W-1:0] global_chi2_rescue;
        logic [PT_W-1:0]   tracker_pt_max_loose;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_hit_count:         8'd12,
        standalone_chi2_max:   16'd2560,
        global_chi2_max_loose: 16'd25600,
        global_chi2_rescue:    16'd1280,
        tracker_pt_max_loose:  22'd1280
    };

    // Result bits, tight_pass in bit 0.
    typedef struct packed {
        logic tracker_loose_pass;
        logic global_loose_pass;
        logic isolated_pass;
        logic tracker_tight_pass;
        logic global_tight_pass;
        logic loose_pass;
        logic tight_pass;
    } t_result;

    // Times five by shift and add.
    function automatic logic [PT_W+2:0] mul5(input logic [PT_W-1:0] x);
        mul5 = {x, 2'b00} + {3'b000, x};
    endfunction

    // Times ten by shift and add.
    function automatic logic [PT_W+3:0] mul10(input logic [PT_W-1:0] x);
        mul10 = {mul5(x), 1'b0};
    endfunction

endpackage

@@ rtl/muqs_cfg_regs.sv @@
// Configuration register file of the muon quality selector.
// Depends on muqs_pkg for the register set type, indexes and reset values.
module muqs_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [muqs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [muqs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output muqs_pkg::t_cfg                    o_cfg
);

    muqs_pkg::t_cfg r_cfg;

    // A write is taken whenever it is offered, so the port is always ready.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register decode; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= muqs_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                muqs_pkg::CFG_MIN_HIT_COUNT: begin
                    r_cfg.min_hit_count <= i_cfg_data[muqs_pkg::HIT8_W-1:0];
                end
                muqs_pkg::CFG_SA_CHI2_MAX: begin
                    r_cfg.standalone_chi2_max <= i_cfg_data[muqs_pkg::CHI2_W-1:0];
                end
                muqs_pkg::CFG_GLB_CHI2_MAX_LOOSE: begin
                    r_cfg.global_chi2_max_loose <= i_cfg_data[muqs_pkg::CHI2_W-1:0];
                end
                muqs_pkg::CFG_GLB_CHI2_RESCUE: begin
                    r_cfg.global_chi2_rescue <= i_cfg_data[muqs_pkg::CHI2_W-1:0];
                end
                muqs_pkg::CFG_TRK_PT_MAX_LOOSE: begin
                    r_cfg.tracker_pt_max_loose <= i_cfg_data[muqs_pkg::PT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/muqs_cut_eval.sv @@
// Cut evaluation for one registered muon candidate.
// Depends on muqs_pkg for the candidate, configuration and result types.
module muqs_cut_eval (
    input  muqs_pkg::t_cand   i_cand,
    input  muqs_pkg::t_cfg    i_cfg,
    output muqs_pkg::t_result o_res
);

    logic [muqs_pkg::FLAGS_W-1:0] w_fl;
    logic [muqs_pkg::HIT8_W-1:0]  w_dt;
    logic [muqs_pkg::HIT8_W-1:0]  w_csc;
    logic [muqs_pkg::HIT8_W-1:0]  w_ntrk;
    logic [muqs_pkg::NMU_W-1:0]   w_nmu;
    logic                         w_mu_hits_ok;
    logic                         w_trk_hits_ok;
    logic [muqs_pkg::PT_W-1:0]    w_spt;
    logic [muqs_pkg::PT_W-1:0]    w_serr;
    logic [muqs_pkg::PT_W-1:0]    w_gpt;
    logic [muqs_pkg::PT_W-1:0]    w_gerr;
    logic [muqs_pkg::PT_W-1:0]    w_tpt;
    logic [muqs_pkg::PT_W-1:0]    w_terr;
    logic [muqs_pkg::CHI2_W-1:0]  w_schi;
    logic [muqs_pkg::CHI2_W-1:0]  w_gchi;
    logic                         w_sa_fail5;
    logic                         w_trk_fail10;
    logic                         w_trk_fail5;
    logic [2*muqs_pkg::PT_W-1:0]  w_prod_g;
    logic [2*muqs_pkg::PT_W-1:0]  w_prod_s;
    logic                         w_better;
    logic                         w_sa_bad;
    logic                         w_gt_bad;
    logic                         w_gl_bad;
    logic [muqs_pkg::PT_W-1:0]    w_min_gs;
    logic [muqs_pkg::PT_W-1:0]    w_smallest;
    logic                         w_iso_ok;
    logic                         w_gt;
    logic                         w_gl;
    logic                         w_tt;
    logic                         w_tl;
    logic                         w_iso;

    // Field extraction.
    assign w_fl   = i_cand.type_flags;
    assign w_dt   = i_cand.hit_counts[7:0];
    assign w_csc  = i_cand.hit_counts[15:8];
    assign w_ntrk = i_cand.hit_counts[23:16];
    assign w_spt  = i_cand.standalone_pt;
    assign w_serr = i_cand.standalone_pt_error;
    assign w_gpt  = i_cand.global_pt;
    assign w_gerr = i_cand.global_pt_error;
    assign w_tpt  = i_cand.tracker_pt;
    assign w_terr = i_cand.tracker_pt_error;
    assign w_schi = i_cand.standalone_chi2;
    assign w_gchi = i_cand.global_chi2;

    // Muon hits count CSC hits twice.
    assign w_nmu = {2'b00, w_dt} + {1'b0, w_csc, 1'b0};
    assign w_mu_hits_ok  = w_nmu > {2'b00, i_cfg.min_hit_count};
    assign w_trk_hits_ok = w_ntrk > i_cfg.min_hit_count;

    // Ratio cuts err/pt > 1/k as k*err > pt; a zero pt fails the cut.
    assign w_sa_fail5   = (w_spt == '0) || (muqs_pkg::mul5(w_serr) > {3'b000, w_spt});
    assign w_trk_fail10 = (w_tpt == '0) || (muqs_pkg::mul10(w_terr) > {4'b0000, w_tpt});
    assign w_trk_fail5  = (w_tpt == '0) || (muqs_pkg::mul5(w_terr) > {3'b000, w_tpt});

    // Global resolution better than both 0.2 and the stand-alone resolution.
    assign w_prod_g = {{muqs_pkg::PT_W{1'b0}}, w_gerr} * {{muqs_pkg::PT_W{1'b0}}, w_spt};
    assign w_prod_s = {{muqs_pkg::PT_W{1'b0}}, w_serr} * {{muqs_pkg::PT_W{1'b0}}, w_gpt};
    assign w_better = (w_gpt != '0) && (w_spt != '0)
                   && (muqs_pkg::mul5(w_gerr) < {3'b000, w_gpt})
                   && (w_prod_g < w_prod_s);

    // Stand-alone quality vetoes of the global branch without a tracker track.
    assign w_sa_bad = (w_schi > i_cfg.standalone_chi2_max) || w_sa_fail5;
    assign w_gt_bad = ((w_dt < muqs_pkg::DT_HITS_MIN) && (w_csc < muqs_pkg::CSC_HITS_MIN))
                   || w_sa_bad;
    assign w_gl_bad = !w_mu_hits_ok || w_sa_bad;

    // Smallest pt for the isolation cut; tracker pt counts only with a track.
    assign w_min_gs   = (w_spt < w_gpt) ? w_spt : w_gpt;
    assign w_smallest = (w_fl[muqs_pkg::FL_TRACKER] && (w_tpt < w_min_gs)) ? w_tpt : w_min_gs;
    assign w_iso_ok   = w_fl[muqs_pkg::FL_ISO_VAL] && w_fl[muqs_pkg::FL_GLOBAL]
                     && (w_fl[muqs_pkg::FL_TRACKER] || (w_dt != '0) || (w_csc != '0));

    // Global tight and global loose.
    always_comb begin
        w_gt = 1'b0;
        w_gl = 1'b0;
        if (w_fl[muqs_pkg::FL_GLOBAL] && w_fl[muqs_pkg::FL_STANDALN]) begin
            if (w_fl[muqs_pkg::FL_TRACKER]) begin
                w_gt = w_fl[muqs_pkg::FL_PROMPT]
                    && (w_fl[muqs_pkg::FL_COMPAT2D] || (w_mu_hits_ok && w_trk_hits_ok));
                w_gl = ((w_fl[muqs_pkg::FL_ONE_ST] && w_mu_hits_ok)
                     || (w_fl[muqs_pkg::FL_LAST_ANG] && w_trk_hits_ok))
                    && (w_gchi < i_cfg.global_chi2_max_loose);
            end else if (w_gchi > w_schi) begin
                w_gt = !w_gt_bad && (w_spt > w_tpt);
                w_gl = !w_gl_bad && ((w_spt > w_tpt) || (w_gchi < i_cfg.global_chi2_rescue));
            end else begin
                w_gt = !w_gt_bad && w_better;
                w_gl = !w_gl_bad && w_better;
            end
        end
    end

    // Tracker tight, tracker loose and isolation.
    assign w_tt  = w_fl[muqs_pkg::FL_TRACKER] && w_trk_hits_ok && w_fl[muqs_pkg::FL_ARBITR]
                && w_fl[muqs_pkg::FL_COMPAT2D] && !w_trk_fail10;
    assign w_tl  = w_fl[muqs_pkg::FL_TRACKER] && !w_trk_fail5
                && (w_tpt <= i_cfg.tracker_pt_max_loose)
                && w_fl[muqs_pkg::FL_ARBITR] && w_fl[muqs_pkg::FL_LAST_ANG];
    assign w_iso = w_iso_ok && (w_smallest != '0)
                && (muqs_pkg::mul10(i_cand.isolation_sum) < {4'b0000, w_smallest});

    // A candidate that is not present fails everything.
    always_comb begin
        o_res = '0;
        if (w_fl[muqs_pkg::FL_PRESENT]) begin
            o_res.global_tight_pass  = w_gt;
            o_res.tracker_tight_pass = w_tt;
            o_res.isolated_pass      = w_iso;
            o_res.global_loose_pass  = w_gl;
            o_res.tracker_loose_pass = w_tl;
            o_res.tight_pass         = w_gt || w_tt || w_iso;
            o_res.loose_pass         = w_gl || w_tl;
        end
    end

endmodule

@@ rtl/muon_id_quality_selector.sv @@
// Top level of the muon identification quality selector.
// Depends on muqs_pkg, muqs_cfg_regs and muqs_cut_eval.
//
// Usage:
// One muon candidate enters per beat on the slave stream: type flags in
// tuser, all other fields packed in tdata. One result beat of seven
// pass/fail bits leaves on the master stream for every candidate, in order.
// The user must write the cut registers through the configuration channel only while
// no candidate is in flight; the block does not enforce this. A write completes in
// the cycle it is offered. An accepted candidate sits in the candidate register,
// is evaluated, and moves into the result register once that register is empty
// or its beat is taken; the result register then offers that beat.
// Throughput is one candidate per cycle while the receiver takes every beat.
// When the receiver stalls, the result register holds its beat and the
// candidate register fills; the input side then stops taking beats until
// the output drains. Reset empties both stages and restores the cut
// registers to their defaults.
module muon_id_quality_selector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata from bit 0: hit_counts, standalone_chi2, global_chi2, standalone_pt,
    // standalone_pt_error, global_pt, global_pt_error, tracker_pt,
    // tracker_pt_error, isolation_sum, zero pad
    input  logic [muqs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser: type_flags
    input  logic [muqs_pkg::FLAGS_W-1:0]         i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata from bit 0: tight_pass, loose_pass, global_tight_pass,
    // tracker_tight_pass, isolated_pass, global_loose_pass, tracker_loose_pass, zero pad
    output logic [muqs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [muqs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [muqs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    muqs_pkg::t_cfg    w_cfg;
    muqs_pkg::t_cand   w_in_cand;
    muqs_pkg::t_result w_res;
    logic              w_in_acc;
    logic              w_s1_adv;

    logic              r_s1_vld;
    logic              n_s1_vld;
    muqs_pkg::t_cand   r_s1_cand;
    logic              r_out_vld;
    logic              n_out_vld;
    muqs_pkg::t_result r_out_res;

    // Cut register file.
    muqs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Unpack the input beat into one candidate.
    assign w_in_cand = {i_s_axis_tuser, i_s_axis_tdata[muqs_pkg::IN_DATA_BITS-1:0]};

    // Pipeline flow: the result register frees up when empty or taken.
    assign w_s1_adv        = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_vld || w_s1_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_s1_vld  = r_s1_vld;
        n_out_vld = r_out_vld;
        if (w_s1_adv) begin
            n_out_vld = r_s1_vld;
        end
        if (o_s_axis_tready) begin
            n_s1_vld = i_s_axis_tvalid;
        end
    end

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Candidate register.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cand <= w_in_cand;
        end
    end

    // Cut evaluation between the two registers.
    muqs_cut_eval u_eval (
        .i_cand (r_s1_cand),
        .i_cfg  (w_cfg),
        .o_res  (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_vld) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(muqs_pkg::OUT_TDATA_W - muqs_pkg::RES_W){1'b0}}, r_out_res};

endmodule

@@ rtl/muqs_checker.sv @@
// Port-level checker for the muon quality selector, with its bind.
// Depends on muqs_pkg for widths; attaches to muon_id_quality_selector.
module muqs_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    input  logic                                 o_s_axis_tready,
    input  logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic [muqs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid after reset");

    // A stalled result beat stays valid and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    // The combined bits agree with the individual selections.
    a_or_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[0] == (o_m_axis_tdata[2] | o_m_axis_tdata[3] | o_m_axis_tdata[4]))
            && (o_m_axis_tdata[1] == (o_m_axis_tdata[5] | o_m_axis_tdata[6])))
        else $error("tight or loose bit disagrees with its parts");

    // An accepted candidate leads to a valid result beat when the output stage moves.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat missing after accepted candidate");

endmodule

bind muon_id_quality_selector muqs_checker u_muqs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ test/muon_id_quality_selector_test.sv @@
// Self-checking testbench for the muon identification quality selector.
// Depends on muqs_pkg and muon_id_quality_selector; drives candidate beats,
// cut register writes and output stalls, and checks every result beat in order.
module muon_id_quality_selector_test;

    typedef logic [muqs_pkg::FLAGS_W-1:0]    t_flags;
    typedef logic [muqs_pkg::PT_W-1:0]       t_pt;
    typedef logic [muqs_pkg::CHI2_W-1:0]     t_chi2;
    typedef logic [muqs_pkg::HIT8_W-1:0]     t_hit8;
    typedef logic [muqs_pkg::NMU_W-1:0]      t_nmu;
    typedef logic [muqs_pkg::CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [muqs_pkg::CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [muqs_pkg::IN_TDATA_W-1:0] t_in_tdata;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int EXTREME_ITEMS  = 50;
    localparam int SPARE_ITEMS    = 20;
    localparam int PHASE_ITEMS    = 270;

    // Inverse ratio limits: err/pt above 1/k fails the cut.
    localparam int unsigned REL_ERR_LOOSE_INV = 5;
    localparam int unsigned REL_ERR_TIGHT_INV = 10;
    localparam int unsigned ISO_INV           = 10;

    localparam t_pt   PT_MAX   = '1;
    localparam t_chi2 CHI2_MAX = '1;
    localparam t_hit8 HIT_MAX  = '1;

    // Register indexes with no register behind them.
    localparam t_cfg_idx CFG_IDX_SPARE_LO = 3'd5;
    localparam t_cfg_idx CFG_IDX_SPARE_HI = 3'd7;

    // Type flag masks.
    localparam t_flags M_PRESENT  = t_flags'(1) << muqs_pkg::FL_PRESENT;
    localparam t_flags M_GLOBAL   = t_flags'(1) << muqs_pkg::FL_GLOBAL;
    localparam t_flags M_TRACKER  = t_flags'(1) << muqs_pkg::FL_TRACKER;
    localparam t_flags M_STANDALN = t_flags'(1) << muqs_pkg::FL_STANDALN;
    localparam t_flags M_ISO_VAL  = t_flags'(1) << muqs_pkg::FL_ISO_VAL;
    localparam t_flags M_PROMPT   = t_flags'(1) << muqs_pkg::FL_PROMPT;
    localparam t_flags M_COMPAT2D = t_flags'(1) << muqs_pkg::FL_COMPAT2D;
    localparam t_flags M_ARBITR   = t_flags'(1) << muqs_pkg::FL_ARBITR;
    localparam t_flags M_ONE_ST   = t_flags'(1) << muqs_pkg::FL_ONE_ST;
    localparam t_flags M_LAST_ANG = t_flags'(1) << muqs_pkg::FL_LAST_ANG;
    localparam t_flags M_GLB_SA   = M_PRESENT | M_GLOBAL | M_STANDALN;

    logic                                 i_clk           = 1'b0;
    logic                                 i_rst_n         = 1'b0;
    logic                                 i_s_axis_tvalid = 1'b0;
    logic                                 o_s_axis_tready;
    logic [muqs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata  = '0;
    logic [muqs_pkg::FLAGS_W-1:0]         i_s_axis_tuser  = '0;
    logic                                 o_m_axis_tvalid;
    logic                                 i_m_axis_tready = 1'b1;
    logic [muqs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata;
    logic                                 i_cfg_valid     = 1'b0;
    logic                                 o_cfg_ready;
    logic [muqs_pkg::CFG_IDX_W-1:0]       i_cfg_index     = '0;
    logic [muqs_pkg::CFG_DATA_W-1:0]      i_cfg_data      = '0;

    // Cut settings as the selector should hold them, and pending verdicts.
    muqs_pkg::t_cfg    cut_regs = muqs_pkg::CFG_RESET;
    muqs_pkg::t_result expected_quality[$];

    int error_count     = 0;
    int candidates_sent = 0;
    int results_checked = 0;
    int tight_seen      = 0;
    int loose_seen      = 0;
    int settings_loaded = 1;
    int source_idle_pct = 0;
    int sink_stall_pct  = 0;

    logic [muqs_pkg::RES_W-1:0] seen_bits;
    logic [muqs_pkg::RES_W-1:0] wanted_bits;

    string result_field [muqs_pkg::RES_W] = '{"tight_pass", "loose_pass",
                                              "global_tight_pass", "tracker_tight_pass",
                                              "isolated_pass", "global_loose_pass",
                                              "tracker_loose_pass"};

    muon_id_quality_selector uut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // True when err/pt exceeds 1/k; a zero pt always fails the cut.
    function automatic logic exceeds_ratio(input t_pt err, input t_pt pt,
                                           input int unsigned k);
        return (pt == '0) || (48'(err) * 48'(k) > 48'(pt));
    endfunction

    // Global relative error below both 0.2 and the stand-alone one.
    function automatic logic global_fit_better(input muqs_pkg::t_cand c);
        if (c.global_pt == '0 || c.standalone_pt == '0) return 1'b0;
        return (48'(c.global_pt_error) * 48'(REL_ERR_LOOSE_INV) < 48'(c.global_pt)) &&
               (48'(c.global_pt_error) * 48'(c.standalone_pt) <
                48'(c.standalone_pt_error) * 48'(c.global_pt));
    endfunction

    // Seven verdicts for one candidate under the given cut settings.
    function automatic muqs_pkg::t_result predict_quality(input muqs_pkg::t_cand c,
                                                          input muqs_pkg::t_cfg r);
        logic glb, trk, sta, prompt, compat, arb, onest, lastang;
        t_hit8 dt, csc, ntrk;
        t_nmu nmu;
        logic mu_ok, trk_ok, sa_bad, gt_bad, gl_bad, better;
        t_pt smallest;
        muqs_pkg::t_result res;
        res = '0;
        if (!c.type_flags[muqs_pkg::FL_PRESENT]) return res;
        glb     = c.type_flags[muqs_pkg::FL_GLOBAL];
        trk     = c.type_flags[muqs_pkg::FL_TRACKER];
        sta     = c.type_flags[muqs_pkg::FL_STANDALN];
        prompt  = c.type_flags[muqs_pkg::FL_PROMPT];
        compat  = c.type_flags[muqs_pkg::FL_COMPAT2D];
        arb     = c.type_flags[muqs_pkg::FL_ARBITR];
        onest   = c.type_flags[muqs_pkg::FL_ONE_ST];
        lastang = c.type_flags[muqs_pkg::FL_LAST_ANG];
        dt      = c.hit_counts[7:0];
        csc     = c.hit_counts[15:8];
        ntrk    = c.hit_counts[23:16];
        nmu     = t_nmu'(dt) + t_nmu'({csc, 1'b0});
        mu_ok   = nmu > t_nmu'(r.min_hit_count);
        trk_ok  = ntrk > r.min_hit_count;

        // Global selections need both a global and a stand-alone fit.
        if (glb && sta) begin
            if (trk) begin
                res.global_tight_pass = prompt && (compat || (mu_ok && trk_ok));
                res.global_loose_pass = ((onest && mu_ok) || (lastang && trk_ok)) &&
                                        (c.global_chi2 < r.global_chi2_max_loose);
            end else begin
                sa_bad = (c.standalone_chi2 > r.standalone_chi2_max) ||
                         exceeds_ratio(c.standalone_pt_error, c.standalone_pt,
                                       REL_ERR_LOOSE_INV);
                gt_bad = ((dt < muqs_pkg::DT_HITS_MIN) && (csc < muqs_pkg::CSC_HITS_MIN))
                         || sa_bad;
                gl_bad = !mu_ok || sa_bad;
                if (c.global_chi2 > c.standalone_chi2) begin
                    res.global_tight_pass = !gt_bad && (c.standalone_pt > c.tracker_pt);
                    res.global_loose_pass = !gl_bad && ((c.standalone_pt > c.tracker_pt) ||
                                            (c.global_chi2 < r.global_chi2_rescue));
                end else begin
                    better = global_fit_better(c);
                    res.global_tight_pass = !gt_bad && better;
                    res.global_loose_pass = !gl_bad && better;
                end
            end
        end

        // Tracker selections.
        if (trk) begin
            res.tracker_tight_pass = trk_ok && arb && compat &&
                !exceeds_ratio(c.tracker_pt_error, c.tracker_pt, REL_ERR_TIGHT_INV);
            res.tracker_loose_pass = arb && lastang &&
                !exceeds_ratio(c.tracker_pt_error, c.tracker_pt, REL_ERR_LOOSE_INV) &&
                (c.tracker_pt <= r.tracker_pt_max_loose);
        end

        // Relative isolation against the smallest available pt.
        if (c.type_flags[muqs_pkg::FL_ISO_VAL] && glb && (trk || dt != '0 || csc != '0)) begin
            smallest = c.global_pt;
            if (c.standalone_pt < smallest) smallest = c.standalone_pt;
            if (trk && c.tracker_pt < smallest) smallest = c.tracker_pt;
            res.isolated_pass = (smallest != '0) &&
                                (48'(c.isolation_sum) * 48'(ISO_INV) < 48'(smallest));
        end

        res.tight_pass = res.global_tight_pass || res.tracker_tight_pass || res.isolated_pass;
        res.loose_pass = res.global_loose_pass || res.tracker_loose_pass;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Result checker: every accepted result beat against the oldest verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_bits = o_m_axis_tdata[muqs_pkg::RES_W-1:0];
            results_checked++;
            if (expected_quality.size() == 0) begin
                report_mismatch($sformatf("result beat %b with no candidate pending",
                                          seen_bits));
            end else begin
                wanted_bits = expected_quality.pop_front();
                for (int b = 0; b < muqs_pkg::RES_W; b++) begin
                    if (seen_bits[b] !== wanted_bits[b]) begin
                        report_mismatch($sformatf("result %0d field %s: got %b, want %b",
                                        results_checked, result_field[b],
                                        seen_bits[b], wanted_bits[b]));
                    end
                end
                tight_seen += int'(wanted_bits[0]);
                loose_seen += int'(wanted_bits[1]);
            end
        end
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Sends one candidate beat after a random idle gap and records its verdict.
    task automatic send_candidate(input muqs_pkg::t_cand c);
        while ($urandom_range(0, 99) < source_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= t_in_tdata'(c[muqs_pkg::IN_DATA_BITS-1:0]);
        i_s_axis_tuser  <= c.type_flags;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_quality.push_back(predict_quality(c, cut_regs));
        candidates_sent++;
    endtask

    // Stops sending and waits until every pending verdict has been matched.
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_quality.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register beat; the caller lowers valid after the last one.
    task automatic write_cut_register(input t_cfg_idx idx, input t_cfg_data value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            muqs_pkg::CFG_MIN_HIT_COUNT: begin
                cut_regs.min_hit_count = value[muqs_pkg::HIT8_W-1:0];
            end
            muqs_pkg::CFG_SA_CHI2_MAX: begin
                cut_regs.standalone_chi2_max = value[muqs_pkg::CHI2_W-1:0];
            end
            muqs_pkg::CFG_GLB_CHI2_MAX_LOOSE: begin
                cut_regs.global_chi2_max_loose = value[muqs_pkg::CHI2_W-1:0];
            end
            muqs_pkg::CFG_GLB_CHI2_RESCUE: begin
                cut_regs.global_chi2_rescue = value[muqs_pkg::CHI2_W-1:0];
            end
            muqs_pkg::CFG_TRK_PT_MAX_LOOSE: begin
                cut_regs.tracker_pt_max_loose = value[muqs_pkg::PT_W-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic load_cut_settings(input muqs_pkg::t_cfg s);
        write_cut_register(muqs_pkg::CFG_MIN_HIT_COUNT, t_cfg_data'(s.min_hit_count));
        write_cut_register(muqs_pkg::CFG_SA_CHI2_MAX, t_cfg_data'(s.standalone_chi2_max));
        write_cut_register(muqs_pkg::CFG_GLB_CHI2_MAX_LOOSE,
                           t_cfg_data'(s.global_chi2_max_loose));
        write_cut_register(muqs_pkg::CFG_GLB_CHI2_RESCUE,
                           t_cfg_data'(s.global_chi2_rescue));
        write_cut_register(muqs_pkg::CFG_TRK_PT_MAX_LOOSE,
                           t_cfg_data'(s.tracker_pt_max_loose));
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic longint near_value(input longint center, input int spread,
                                          input longint ceiling);
        longint v;
        v = center + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > ceiling) v = ceiling;
        return v;
    endfunction

    function automatic t_pt random_pt();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return PT_MAX;
            2, 3, 4, 5: return t_pt'($urandom_range(1, 4096));
            default:    return t_pt'($urandom);
        endcase
    endfunction

    // Mostly close to the ratio boundary pt/k, sometimes anywhere.
    function automatic t_pt random_error(input t_pt pt, input int unsigned k);
        case ($urandom_range(0, 5))
            0:       return t_pt'($urandom);
            1:       return '0;
            default: return t_pt'(near_value(pt / k, 2, PT_MAX));
        endcase
    endfunction

    function automatic t_chi2 random_chi2(input t_chi2 center);
        if ($urandom_range(0, 9) < 6) return t_chi2'(near_value(center, 3, CHI2_MAX));
        return t_chi2'($urandom);
    endfunction

    function automatic t_hit8 random_hits(input int unsigned limit);
        if ($urandom_range(0, 3) != 0) return t_hit8'($urandom_range(0, limit));
        return t_hit8'($urandom);
    endfunction

    // Mostly present global/stand-alone candidates with values near the cuts.
    function automatic muqs_pkg::t_cand random_candidate();
        muqs_pkg::t_cand c;
        t_pt low_pt;
        if ($urandom_range(0, 9) == 0) begin
            c.type_flags = t_flags'($urandom);
        end else begin
            c.type_flags = t_flags'($urandom) | M_PRESENT;
            if ($urandom_range(0, 9) < 7) c.type_flags |= M_GLB_SA;
        end
        c.hit_counts = {random_hits(30), random_hits(12), random_hits(40)};
        c.standalone_chi2 = random_chi2(cut_regs.standalone_chi2_max);
        case ($urandom_range(0, 3))
            0:       c.global_chi2 = random_chi2(c.standalone_chi2);
            1:       c.global_chi2 = random_chi2(cut_regs.global_chi2_max_loose);
            2:       c.global_chi2 = random_chi2(cut_regs.global_chi2_rescue);
            default: c.global_chi2 = t_chi2'($urandom);
        endcase
        c.standalone_pt       = random_pt();
        c.standalone_pt_error = random_error(c.standalone_pt, REL_ERR_LOOSE_INV);
        c.global_pt = $urandom_range(0, 1) ? t_pt'(near_value(c.standalone_pt, 4, PT_MAX))
                                           : random_pt();
        c.global_pt_error = $urandom_range(0, 1)
                          ? t_pt'(near_value(c.standalone_pt_error, 2, PT_MAX))
                          : random_error(c.global_pt, REL_ERR_LOOSE_INV);
        case ($urandom_range(0, 3))
            0:       c.tracker_pt = t_pt'(near_value(c.standalone_pt, 2, PT_MAX));
            1:       c.tracker_pt = t_pt'(near_value(cut_regs.tracker_pt_max_loose, 1,
                                                     PT_MAX));
            default: c.tracker_pt = random_pt();
        endcase
        c.tracker_pt_error = random_error(c.tracker_pt, $urandom_range(0, 1)
                                          ? REL_ERR_TIGHT_INV : REL_ERR_LOOSE_INV);
        low_pt = c.global_pt;
        if (c.standalone_pt < low_pt) low_pt = c.standalone_pt;
        if (c.tracker_pt < low_pt) low_pt = c.tracker_pt;
        c.isolation_sum = ($urandom_range(0, 3) == 0) ? t_pt'($urandom)
                        : t_pt'(near_value(low_pt / ISO_INV, 2, PT_MAX));
        return c;
    endfunction

    function automatic muqs_pkg::t_cfg random_cut_settings();
        muqs_pkg::t_cfg s;
        s.min_hit_count = ($urandom_range(0, 3) == 0) ? t_hit8'($urandom)
                                                      : t_hit8'($urandom_range(0, 30));
        s.standalone_chi2_max = ($urandom_range(0, 3) == 0) ? t_chi2'($urandom)
            : t_chi2'(near_value(muqs_pkg::CFG_RESET.standalone_chi2_max, 1024, CHI2_MAX));
        s.global_chi2_max_loose = ($urandom_range(0, 3) == 0) ? t_chi2'($urandom)
            : t_chi2'(near_value(muqs_pkg::CFG_RESET.global_chi2_max_loose, 4096,
                                 CHI2_MAX));
        s.global_chi2_rescue = ($urandom_range(0, 3) == 0) ? t_chi2'($urandom)
            : t_chi2'(near_value(muqs_pkg::CFG_RESET.global_chi2_rescue, 512, CHI2_MAX));
        s.tracker_pt_max_loose = ($urandom_range(0, 3) == 0) ? t_pt'($urandom)
            : t_pt'($urandom_range(0, 8192));
        return s;
    endfunction

    function automatic muqs_pkg::t_cand make_candidate(
        input t_flags flags, input t_hit8 dt, input t_hit8 csc, input t_hit8 ntrk,
        input t_chi2 schi, input t_chi2 gchi,
        input t_pt spt, input t_pt serr, input t_pt gpt, input t_pt gerr,
        input t_pt tpt, input t_pt terr, input t_pt iso);
        muqs_pkg::t_cand c;
        c.type_flags          = flags;
        c.hit_counts          = {ntrk, csc, dt};
        c.standalone_chi2     = schi;
        c.global_chi2         = gchi;
        c.standalone_pt       = spt;
        c.standalone_pt_error = serr;
        c.global_pt           = gpt;
        c.global_pt_error     = gerr;
        c.tracker_pt          = tpt;
        c.tracker_pt_error    = terr;
        c.isolation_sum       = iso;
        return c;
    endfunction

    // Field extremes and each cut boundary under the reset settings.
    task automatic test_directed_cases();
        // Absent candidate with everything else set, then all ones, then all zeros.
        send_candidate(make_candidate(~M_PRESENT, HIT_MAX, HIT_MAX, HIT_MAX, CHI2_MAX,
                       CHI2_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX));
        send_candidate(make_candidate('1, HIT_MAX, HIT_MAX, HIT_MAX, CHI2_MAX, CHI2_MAX,
                       PT_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX, PT_MAX));
        send_candidate(make_candidate(M_PRESENT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Global with tracker: 2D compatibility, then hit counts just above the cut.
        send_candidate(make_candidate(M_GLB_SA | M_TRACKER | M_PROMPT | M_COMPAT2D,
                       10, 5, 20, 100, 100, 6400, 64, 6400, 64, 6400, 64, 0));
        send_candidate(make_candidate(M_GLB_SA | M_TRACKER | M_PROMPT | M_ONE_ST,
                       13, 0, 13, 100, 25599, 6400, 64, 6400, 64, 6400, 64, 0));
        send_candidate(make_candidate(M_GLB_SA | M_TRACKER | M_ONE_ST | M_LAST_ANG,
                       13, 0, 13, 100, 25600, 6400, 64, 6400, 64, 6400, 64, 0));
        // Global without tracker, worse global chi2: pt comparison and rescue.
        send_candidate(make_candidate(M_GLB_SA, 22, 0, 0, 2560, 2561,
                       6400, 1280, 6400, 64, 6399, 64, 0));
        send_candidate(make_candidate(M_GLB_SA, 22, 0, 0, 100, 1279,
                       6400, 64, 6400, 64, 6400, 64, 0));
        // Equal global and stand-alone chi2: combined ratio limit, its equality and zero pt.
        send_candidate(make_candidate(M_GLB_SA, 21, 15, 0, 2000, 2000,
                       6400, 1280, 6400, 1279, 6400, 64, 0));
        send_candidate(make_candidate(M_GLB_SA, 21, 15, 0, 2000, 2000,
                       6400, 1280, 0, 1279, 6400, 64, 0));
        send_candidate(make_candidate(M_GLB_SA, 30, 15, 0, 2000, 2000,
                       6400, 2000, 6400, 1280, 6400, 64, 0));
        // Stand-alone failures: zero pt and saturated chi2.
        send_candidate(make_candidate(M_GLB_SA, 30, 20, 0, 100, 200,
                       0, 0, 6400, 64, 100, 64, 0));
        send_candidate(make_candidate(M_GLB_SA, 30, 20, 0, CHI2_MAX, CHI2_MAX,
                       6400, 64, 6400, 64, 100, 64, 0));
        // Too few DT and CSC hits for tight, enough muon hits for loose.
        send_candidate(make_candidate(M_GLB_SA, 21, 14, 0, 100, 200,
                       6400, 64, 6400, 64, 100, 64, 0));
        // Tracker cuts at the ratio limits, zero pt and the loose pt ceiling.
        send_candidate(make_candidate(M_PRESENT | M_TRACKER | M_ARBITR | M_COMPAT2D |
                       M_LAST_ANG, 0, 0, 13, 0, 0, 0, 0, 0, 0, 640, 64, 0));
        send_candidate(make_candidate(M_PRESENT | M_TRACKER | M_ARBITR | M_COMPAT2D |
                       M_LAST_ANG, 0, 0, 13, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_candidate(make_candidate(M_PRESENT | M_TRACKER | M_ARBITR | M_LAST_ANG,
                       0, 0, 0, 0, 0, 0, 0, 0, 0, 1280, 100, 0));
        send_candidate(make_candidate(M_PRESENT | M_TRACKER | M_ARBITR | M_LAST_ANG,
                       0, 0, 0, 0, 0, 0, 0, 0, 0, 1281, 100, 0));
        // Isolation just inside and just outside one tenth of the smallest pt.
        send_candidate(make_candidate(M_PRESENT | M_GLOBAL | M_ISO_VAL, 1, 0, 0, 0, 0,
                       6400, 0, 6400, 0, 0, 0, 639));
        send_candidate(make_candidate(M_PRESENT | M_GLOBAL | M_ISO_VAL, 0, 1, 0, 0, 0,
                       6400, 0, 6400, 0, 0, 0, 640));
        // Isolation without muon hits or tracker is never granted.
        send_candidate(make_candidate(M_PRESENT | M_GLOBAL | M_ISO_VAL, 0, 0, 0, 0, 0,
                       6400, 0, 6400, 0, 0, 0, 0));
        // Tracker pt is the smallest, then a zero smallest pt.
        send_candidate(make_candidate(M_PRESENT | M_GLOBAL | M_TRACKER | M_ISO_VAL,
                       0, 0, 0, 0, 0, 6400, 0, 6400, 0, 100, 0, 9));
        send_candidate(make_candidate(M_PRESENT | M_GLOBAL | M_TRACKER | M_ISO_VAL,
                       0, 0, 0, 0, 0, 6400, 0, 0, 0, 100, 0, 0));
    endtask

    // All cut registers at their lowest, then their highest, then spare indexes.
    task automatic test_register_extremes();
        wait_results_drained();
        load_cut_settings(muqs_pkg::t_cfg'('0));
        repeat (EXTREME_ITEMS) send_candidate(random_candidate());
        wait_results_drained();
        load_cut_settings(muqs_pkg::t_cfg'('1));
        repeat (EXTREME_ITEMS) send_candidate(random_candidate());
        wait_results_drained();
        // Writes to unused indexes must leave every register alone.
        write_cut_register(CFG_IDX_SPARE_LO, t_cfg_data'($urandom));
        write_cut_register(CFG_IDX_SPARE_HI, '0);
        i_cfg_valid <= 1'b0;
        repeat (SPARE_ITEMS) send_candidate(random_candidate());
    endtask

    // Random candidates under fresh settings in each idle and stall mix.
    task automatic test_idle_phases();
        int source_pct [4] = '{0, 70, 0, 21};
        int sink_pct   [4] = '{0, 0, 70, 21};
        for (int p = 0; p < 4; p++) begin
            wait_results_drained();
            load_cut_settings(random_cut_settings());
            source_idle_pct = source_pct[p];
            sink_stall_pct  = sink_pct[p];
            repeat (PHASE_ITEMS / 2) send_candidate(random_candidate());
            // Let the pipeline run empty before the second half of the phase.
            wait_results_drained();
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) send_candidate(random_candidate());
        end
        source_idle_pct = 0;
        sink_stall_pct  = 0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_register_extremes();
        test_idle_phases();
        wait_results_drained();
        $display("Covered %0d candidates under %0d cut settings and four idle/stall mixes.",
                 candidates_sent, settings_loaded);
        $display("Checked %0d result beats: %0d tight and %0d loose passes expected.",
                 results_checked, tight_seen, loose_seen);
        if (error_count == 0) begin
            $display("muon_id_quality_selector regression: pass");
        end else begin
            $display("muon_id_quality_selector regression: fail");
        end
        $finish;
    end

    // Watchdog against a stalled handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("muon_id_quality_selector regression: fail");
        $finish;
    end

endmodule
